### design/encpid_pkg.sv
// Shared types, constants and helpers for the encoder PID speed controller.
`default_nettype none
package encpid_pkg;

   localparam int COUNT_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int SPEED_W    = 16;
   localparam int ERR_W      = SPEED_W + 1;
   localparam int GAIN_W     = 24;
   localparam int DUTY_W     = 17;
   localparam int ACC_W      = 46;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = GAIN_W;

   localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = GAIN_W'(1311);
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = GAIN_W'(328);
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = '0;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TARGET_SPEED  = 3'd0,
      CSR_PROP_GAIN     = 3'd1,
      CSR_INTEG_GAIN    = 3'd2,
      CSR_DERIV_GAIN    = 3'd3,
      CSR_LOOP_ENABLE   = 3'd4,
      CSR_POLARITY_SWAP = 3'd5
   } csr_index_type;

   typedef enum logic {
      REQ_EDGE = 1'b0,
      REQ_TICK = 1'b1
   } req_kind_type;

   // Bit 0 drives the first direction pin, bit 1 the second.
   localparam logic [1:0] PINS_ONE = 2'b01;
   localparam logic [1:0] PINS_TWO = 2'b10;

   function automatic logic [1:0] drive_pins(input logic forward, input logic swap);
      return (forward ^ swap) ? PINS_ONE : PINS_TWO;
   endfunction

endpackage
`default_nettype wire

### design/encpid_if.sv
// Request, response and register write channel interfaces.
`default_nettype none
interface encpid_req_if;
   logic valid;
   logic ready;
   logic req_type;
   logic enc_a;
   logic enc_b;
   modport source (output valid, output req_type, output enc_a, output enc_b, input ready);
   modport sink   (input valid, input req_type, input enc_a, input enc_b, output ready);
endinterface

interface encpid_rsp_if;
   import encpid_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [DUTY_W-1:0]          duty;
   logic                       dir_one;
   logic                       dir_two;
   logic signed [SPEED_W-1:0]  measured_speed;
   modport source (output valid, output duty, output dir_one, output dir_two,
                   output measured_speed, input ready);
   modport sink   (input valid, input duty, input dir_one, input dir_two,
                   input measured_speed, output ready);
endinterface

interface encpid_csr_if;
   import encpid_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

### design/encpid_pid.sv
// One PID step: error, three gain products, integrator and output clamps.
`default_nettype none
module encpid_pid #(
   parameter int FRAC_BITS = encpid_pkg::FRAC_BITS_DEF
) (
   input  logic signed [encpid_pkg::SPEED_W-1:0] target_speed,
   input  logic signed [encpid_pkg::SPEED_W-1:0] speed,
   input  logic [encpid_pkg::GAIN_W-1:0]         prop_gain,
   input  logic [encpid_pkg::GAIN_W-1:0]         integ_gain,
   input  logic [encpid_pkg::GAIN_W-1:0]         deriv_gain,
   input  logic signed [FRAC_BITS+1:0]           integ_cur,
   input  logic signed [encpid_pkg::ERR_W-1:0]   prev_err,
   output logic signed [FRAC_BITS+1:0]           integ_next,
   output logic signed [encpid_pkg::ERR_W-1:0]   err,
   output logic [encpid_pkg::DUTY_W-1:0]         duty,
   output logic                                  forward
);
   import encpid_pkg::*;

   localparam int MAG_W  = FRAC_BITS + 1;
   localparam int SHR    = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int SHL    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam int WIDE_W = MAG_W + SHL;
   localparam logic signed [ACC_W-1:0] ONE     = ACC_W'(1) << FRAC_BITS;
   localparam logic signed [ACC_W-1:0] NEG_ONE = -ONE;

   logic signed [ERR_W:0]            derr;
   logic signed [GAIN_W:0]           kp_s;
   logic signed [GAIN_W:0]           ki_s;
   logic signed [GAIN_W:0]           kd_s;
   logic signed [GAIN_W+ERR_W:0]     p_prod;
   logic signed [GAIN_W+ERR_W:0]     i_prod;
   logic signed [GAIN_W+ERR_W+1:0]   d_prod;
   logic signed [ACC_W-1:0]          integ_sum;
   logic signed [ACC_W-1:0]          integ_clamp;
   logic signed [ACC_W-1:0]          out_sum;
   logic signed [ACC_W-1:0]          out_clamp;
   logic signed [ACC_W-1:0]          out_abs;
   logic [MAG_W-1:0]                 mag;
   logic [WIDE_W-1:0]                wide;

   always_comb begin
      err  = $signed({target_speed[SPEED_W-1], target_speed}) -
             $signed({speed[SPEED_W-1], speed});
      derr = $signed({err[ERR_W-1], err}) - $signed({prev_err[ERR_W-1], prev_err});
      kp_s = $signed({1'b0, prop_gain});
      ki_s = $signed({1'b0, integ_gain});
      kd_s = $signed({1'b0, deriv_gain});
      p_prod = kp_s * err;
      i_prod = ki_s * err;
      d_prod = kd_s * derr;

      // The output uses the integrator sum before it is clamped.
      integ_sum = ACC_W'(integ_cur) + ACC_W'(i_prod);
      out_sum   = ACC_W'(p_prod) + integ_sum + ACC_W'(d_prod);

      if (integ_sum > ONE) begin
         integ_clamp = ONE;
      end else if (integ_sum < NEG_ONE) begin
         integ_clamp = NEG_ONE;
      end else begin
         integ_clamp = integ_sum;
      end
      integ_next = integ_clamp[FRAC_BITS+1:0];

      if (out_sum > ONE) begin
         out_clamp = ONE;
      end else if (out_sum < NEG_ONE) begin
         out_clamp = NEG_ONE;
      end else begin
         out_clamp = out_sum;
      end

      // An output of exactly zero counts as backward.
      forward = (out_clamp > 0);
      out_abs = forward ? out_clamp : -out_clamp;
      mag     = out_abs[MAG_W-1:0];
      wide    = WIDE_W'(mag) << SHL;
      duty    = DUTY_W'(wide >> SHR);
   end

endmodule
`default_nettype wire

### design/encoder_pid_speed_controller_unit.sv
// Top level: input register, edge counter, PID step and response register.
// Throughput is one request per cycle unless a tick waits for room in the response register;
// an edge request gives no response. A tick request is held in the input register and then,
// once the response register has room, its response is loaded into the response register.
// The PID datapath is combinational, with the three gain products in parallel.
// Synchronous reset restores the register defaults and clears count, integrator and drive.
`default_nettype none
module encoder_pid_speed_controller_unit #(
   parameter int COUNT_BITS = encpid_pkg::COUNT_BITS_DEF,
   parameter int FRAC_BITS  = encpid_pkg::FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   encpid_req_if.sink   req_ch,
   encpid_rsp_if.source rsp_ch,
   encpid_csr_if.sink   csr_ch
);
   import encpid_pkg::*;

   localparam int INT_W = FRAC_BITS + 2;

   // Configuration registers.
   logic signed [SPEED_W-1:0] target_ff, target_in;
   logic [GAIN_W-1:0]         kp_ff, kp_in;
   logic [GAIN_W-1:0]         ki_ff, ki_in;
   logic [GAIN_W-1:0]         kd_ff, kd_in;
   logic                      enable_ff, enable_in;
   logic                      swap_ff, swap_in;

   // Input register.
   logic                      stage_valid_ff, stage_valid_in;
   req_kind_type              stage_kind_ff;
   logic                      stage_a_ff;
   logic                      stage_b_ff;

   // Block state.
   logic                      last_a_ff, last_a_in;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic signed [INT_W-1:0]   integ_ff, integ_in;
   logic signed [ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic [DUTY_W-1:0]         drive_duty_ff, drive_duty_in;
   logic [1:0]                drive_pins_ff, drive_pins_in;

   // Response register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]         rsp_duty_ff, rsp_duty_in;
   logic [1:0]                rsp_pins_ff, rsp_pins_in;
   logic signed [SPEED_W-1:0] rsp_speed_ff, rsp_speed_in;

   logic                      is_tick;
   logic                      advance;
   logic                      accept;
   logic signed [SPEED_W-1:0] speed;
   logic signed [INT_W-1:0]   pid_integ;
   logic signed [ERR_W-1:0]   pid_err;
   logic [DUTY_W-1:0]         pid_duty;
   logic                      pid_forward;

   assign is_tick = (stage_kind_ff == REQ_TICK);
   // An edge request always moves on; a tick needs room in the response register.
   assign advance = stage_valid_ff && (!is_tick || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !stage_valid_ff || advance;
   assign accept = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // Low 16 bits of the count, read as signed.
   assign speed = $signed(SPEED_W'(count_ff));

   encpid_pid #(
      .FRAC_BITS (FRAC_BITS)
   ) u_pid (
      .target_speed (target_ff),
      .speed        (speed),
      .prop_gain    (kp_ff),
      .integ_gain   (ki_ff),
      .deriv_gain   (kd_ff),
      .integ_cur    (integ_ff),
      .prev_err     (prev_err_ff),
      .integ_next   (pid_integ),
      .err          (pid_err),
      .duty         (pid_duty),
      .forward      (pid_forward)
   );

   always_comb begin
      target_in      = target_ff;
      kp_in          = kp_ff;
      ki_in          = ki_ff;
      kd_in          = kd_ff;
      enable_in      = enable_ff;
      swap_in        = swap_ff;
      stage_valid_in = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_ff);
      last_a_in      = last_a_ff;
      count_in       = count_ff;
      integ_in       = integ_ff;
      prev_err_in    = prev_err_ff;
      drive_duty_in  = drive_duty_ff;
      drive_pins_in  = drive_pins_ff;
      rsp_duty_in    = rsp_duty_ff;
      rsp_pins_in    = rsp_pins_ff;
      rsp_speed_in   = rsp_speed_ff;
      rsp_valid_in   = rsp_ch.ready ? 1'b0 : rsp_valid_ff;

      if (advance) begin
         if (!is_tick) begin
            if (last_a_ff ^ stage_b_ff) begin
               count_in = count_ff + COUNT_BITS'(1);
            end else begin
               count_in = count_ff - COUNT_BITS'(1);
            end
            last_a_in = stage_a_ff;
         end else begin
            count_in = '0;
            if (enable_ff) begin
               integ_in    = pid_integ;
               prev_err_in = pid_err;
               // A zero setpoint still runs the step but forces zero duty forward.
               if (target_ff == '0) begin
                  drive_duty_in = '0;
                  drive_pins_in = drive_pins(1'b1, swap_ff);
               end else begin
                  drive_duty_in = pid_duty;
                  drive_pins_in = drive_pins(pid_forward, swap_ff);
               end
            end
            rsp_valid_in = 1'b1;
            rsp_duty_in  = drive_duty_in;
            rsp_pins_in  = drive_pins_in;
            rsp_speed_in = speed;
         end
      end

      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.addr))
            CSR_TARGET_SPEED: begin
               target_in = $signed(csr_ch.data[SPEED_W-1:0]);
               if (csr_ch.data[SPEED_W-1:0] == '0) begin
                  integ_in      = '0;
                  drive_duty_in = '0;
                  drive_pins_in = drive_pins(1'b1, swap_ff);
               end
            end
            CSR_PROP_GAIN:     kp_in = csr_ch.data;
            CSR_INTEG_GAIN:    ki_in = csr_ch.data;
            CSR_DERIV_GAIN:    kd_in = csr_ch.data;
            CSR_LOOP_ENABLE:   enable_in = csr_ch.data[0];
            CSR_POLARITY_SWAP: swap_in = csr_ch.data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff      <= '0;
         kp_ff          <= PROP_GAIN_RST;
         ki_ff          <= INTEG_GAIN_RST;
         kd_ff          <= DERIV_GAIN_RST;
         enable_ff      <= 1'b1;
         swap_ff        <= 1'b0;
         stage_valid_ff <= 1'b0;
         last_a_ff      <= 1'b0;
         count_ff       <= '0;
         integ_ff       <= '0;
         prev_err_ff    <= '0;
         drive_duty_ff  <= '0;
         drive_pins_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         target_ff      <= target_in;
         kp_ff          <= kp_in;
         ki_ff          <= ki_in;
         kd_ff          <= kd_in;
         enable_ff      <= enable_in;
         swap_ff        <= swap_in;
         stage_valid_ff <= stage_valid_in;
         last_a_ff      <= last_a_in;
         count_ff       <= count_in;
         integ_ff       <= integ_in;
         prev_err_ff    <= prev_err_in;
         drive_duty_ff  <= drive_duty_in;
         drive_pins_ff  <= drive_pins_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_kind_ff <= req_kind_type'(req_ch.req_type);
         stage_a_ff    <= req_ch.enc_a;
         stage_b_ff    <= req_ch.enc_b;
      end
      rsp_duty_ff  <= rsp_duty_in;
      rsp_pins_ff  <= rsp_pins_in;
      rsp_speed_ff <= rsp_speed_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.duty           = rsp_duty_ff;
   assign rsp_ch.dir_one        = rsp_pins_ff[0];
   assign rsp_ch.dir_two        = rsp_pins_ff[1];
   assign rsp_ch.measured_speed = rsp_speed_ff;

endmodule
`default_nettype wire
